>>> src/sp2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp2c_pkg: shared types and constants for the scan polar-to-cartesian core
// Field widths, register codes, CORDIC constants and the queue word layout.
// ----------------------------------------------------------------------------
package sp2c_pkg;

    localparam int RANGE_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int STEP_W      = 12;
    localparam int INDEX_W     = 12;
    localparam int COORD_W     = 17;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Q16 mm datapath and 2^-32 turn residual angle
    localparam int XY_W = 36;
    localparam int Z_W  = 34;
    localparam int RND_W = XY_W - 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
    localparam logic [31:0] ATAN_Q32 [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [RND_W:0] SAT_HI = (RND_W+1)'(65535);
    localparam logic signed [RND_W:0] SAT_LO = -(RND_W+1)'(65535);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RANGE_MIN   = 4'd0,
        CFG_RANGE_MAX   = 4'd1,
        CFG_START_ANGLE = 4'd2,
        CFG_ANGLE_STEP  = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] angle;
        logic [INDEX_W-1:0] beam_index;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage
`default_nettype wire

>>> src/sp2c_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp2c_if: channel interfaces of the scan polar-to-cartesian core
// Range sample input, point output and register write channels.
// ----------------------------------------------------------------------------
interface sp2c_sample_if;
    logic                             valid;
    logic                             ready;
    logic [sp2c_pkg::RANGE_W-1:0]     range_mm;
    logic                             scan_start;

    modport source (output valid, output range_mm, output scan_start, input ready);
    modport sink (input valid, input range_mm, input scan_start, output ready);
endinterface

interface sp2c_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [sp2c_pkg::COORD_W-1:0] x_mm;
    logic signed [sp2c_pkg::COORD_W-1:0] y_mm;
    logic [sp2c_pkg::INDEX_W-1:0]        beam_index;

    modport source (output valid, output x_mm, output y_mm, output beam_index, input ready);
    modport sink (input valid, input x_mm, input y_mm, input beam_index, output ready);
endinterface

interface sp2c_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sp2c_pkg::CFG_INDEX_W-1:0]  index;
    logic [sp2c_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/sp2c_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp2c_front: sample intake and classification
// Holds the registers and beam counter, gates samples by range and forms the
// beam angle of each kept sample for the queue.
// ----------------------------------------------------------------------------
module sp2c_front #(
    parameter int MAX_BEAMS = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sp2c_sample_if.sink                sample,
    sp2c_cfg_if.sink                   cfg,
    input  wire sp2c_pkg::queue_stat_t q_stat,
    output logic                       push,
    output sp2c_pkg::job_t             push_job
);

    localparam logic [16:0] BEAM_LIMIT = 17'(MAX_BEAMS);

    logic [sp2c_pkg::RANGE_W-1:0] range_min_reg;
    logic [sp2c_pkg::RANGE_W-1:0] range_max_reg;
    logic [sp2c_pkg::ANGLE_W-1:0] start_angle_reg;
    logic [sp2c_pkg::STEP_W-1:0]  angle_step_reg;
    logic [sp2c_pkg::INDEX_W-1:0] beam_counter_reg;
    logic [sp2c_pkg::INDEX_W-1:0] beam_counter_next;

    logic                         accept;
    logic                         in_window;
    logic [sp2c_pkg::INDEX_W-1:0] index;
    logic [16:0]                  index_inc;
    logic [23:0]                  angle_offset;

    assign sample.ready = !q_stat.full;
    assign cfg.ready    = 1'b1;
    assign accept       = sample.valid && sample.ready;

    assign index        = sample.scan_start ? '0 : beam_counter_reg;
    assign index_inc    = 17'(index) + 17'd1;
    assign beam_counter_next = (index_inc >= BEAM_LIMIT) ? '0
                                                         : index_inc[sp2c_pkg::INDEX_W-1:0];

    assign in_window    = (sample.range_mm > range_min_reg) &&
                          (sample.range_mm < range_max_reg);
    assign angle_offset = 24'(index) * 24'(angle_step_reg);

    assign push                = accept && in_window;
    assign push_job.range_mm   = sample.range_mm;
    assign push_job.angle      = start_angle_reg + angle_offset[sp2c_pkg::ANGLE_W-1:0];
    assign push_job.beam_index = index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_counter_reg <= '0;
        end
        else if (accept)
        begin
            beam_counter_reg <= beam_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= '0;
            range_max_reg   <= 16'hFFFF;
            start_angle_reg <= '0;
            angle_step_reg  <= 12'd16;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                sp2c_pkg::CFG_RANGE_MIN:   range_min_reg   <= cfg.data;
                sp2c_pkg::CFG_RANGE_MAX:   range_max_reg   <= cfg.data;
                sp2c_pkg::CFG_START_ANGLE: start_angle_reg <= cfg.data;
                sp2c_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg.data[sp2c_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/sp2c_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp2c_queue: two-entry job queue
// Decouples sample intake from the rotation unit.
// ----------------------------------------------------------------------------
module sp2c_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sp2c_pkg::job_t        push_job,
    input  wire logic                  pop,
    output sp2c_pkg::job_t             head,
    output sp2c_pkg::queue_stat_t      stat
);

    sp2c_pkg::job_t mem [0:1];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/sp2c_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp2c_cordic: iterative CORDIC rotation unit
// Takes one job from the queue, scales the range by the gain, rotates one
// stage a cycle, then rounds, restores the half turn and saturates.
// ----------------------------------------------------------------------------
module sp2c_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sp2c_pkg::job_t        head,
    input  wire sp2c_pkg::queue_stat_t q_stat,
    output logic                       pop,
    sp2c_point_if.source               point
);

    localparam int STAGE_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(CORDIC_STAGES - 1);
    localparam int XY_W  = sp2c_pkg::XY_W;
    localparam int Z_W   = sp2c_pkg::Z_W;
    localparam int RND_W = sp2c_pkg::RND_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ROT  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                          state_reg;
    logic signed [XY_W-1:0]          x_reg;
    logic signed [XY_W-1:0]          y_reg;
    logic signed [Z_W-1:0]           z_reg;
    logic [STAGE_W-1:0]              stage_reg;
    logic                            flip_reg;
    logic [sp2c_pkg::INDEX_W-1:0]    index_reg;
    logic                            out_valid_reg;
    logic signed [sp2c_pkg::COORD_W-1:0] x_mm_reg;
    logic signed [sp2c_pkg::COORD_W-1:0] y_mm_reg;
    logic [sp2c_pkg::INDEX_W-1:0]    beam_index_reg;

    logic                            load_out;
    logic                            flip;
    logic [sp2c_pkg::ANGLE_W-1:0]    residual;
    logic [47:0]                     scaled;
    logic signed [XY_W-1:0]          dx;
    logic signed [XY_W-1:0]          dy;
    logic signed [Z_W-1:0]           atan;

    function automatic logic signed [sp2c_pkg::COORD_W-1:0] finish_coord(
        input logic signed [XY_W-1:0] v,
        input logic                   neg
    );
        logic signed [XY_W-1:0]  biased;
        logic signed [RND_W:0]   whole;
        biased = v + XY_W'(32768);
        whole  = (RND_W+1)'($signed(biased[XY_W-1:16]));
        if (neg)
        begin
            whole = -whole;
        end
        if (whole > sp2c_pkg::SAT_HI)
        begin
            whole = sp2c_pkg::SAT_HI;
        end
        else if (whole < sp2c_pkg::SAT_LO)
        begin
            whole = sp2c_pkg::SAT_LO;
        end
        return whole[sp2c_pkg::COORD_W-1:0];
    endfunction

    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || point.ready);

    assign flip     = head.angle[15] ^ head.angle[14];
    assign residual = flip ? (head.angle ^ 16'h8000) : head.angle;
    assign scaled   = 48'(head.range_mm) * 48'(sp2c_pkg::GAIN_Q32);

    assign dx   = y_reg >>> stage_reg;
    assign dy   = x_reg >>> stage_reg;
    assign atan = Z_W'(sp2c_pkg::ATAN_Q32[sp2c_pkg::ATAN_IDX_W'(stage_reg)]);

    assign point.valid      = out_valid_reg;
    assign point.x_mm       = x_mm_reg;
    assign point.y_mm       = y_mm_reg;
    assign point.beam_index = beam_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    if (stage_reg == LAST_STAGE)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg     <= XY_W'(scaled[47:16]);
            y_reg     <= '0;
            z_reg     <= {{(Z_W-32){residual[15]}}, residual, 16'h0000};
            stage_reg <= '0;
            flip_reg  <= flip;
            index_reg <= head.beam_index;
        end
        else if (state_reg == ST_ROT)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan;
            end
            stage_reg <= stage_reg + STAGE_W'(1);
        end
        if (load_out)
        begin
            x_mm_reg       <= finish_coord(x_reg, flip_reg);
            y_mm_reg       <= finish_coord(y_reg, flip_reg);
            beam_index_reg <= index_reg;
        end
    end

endmodule
`default_nettype wire

>>> src/scan_polar_to_cartesian_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_core: lidar range samples to x/y points
// Beam indexing, range gating and gain-compensated CORDIC rotation.
// ----------------------------------------------------------------------------
// A sample is taken whenever the two-entry job queue has room; samples
// outside the range window leave no job, though they too wait while the
// queue is full. Each kept sample occupies the single shared CORDIC unit
// (gain scaling, rotation stages, rounding and saturation) until its point
// is loaded into the point register, and the unit takes no new job before
// that; the point register lets the next job proceed while a point waits.
// Registers are written through the cfg channel, which is always ready.
module scan_polar_to_cartesian_core #(
    parameter int MAX_BEAMS     = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sp2c_sample_if.sink   sample,
    sp2c_cfg_if.sink      cfg,
    sp2c_point_if.source  point
);

    logic                  push;
    logic                  pop;
    sp2c_pkg::job_t        push_job;
    sp2c_pkg::job_t        head;
    sp2c_pkg::queue_stat_t q_stat;

    sp2c_front #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    sp2c_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    sp2c_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .point  (point)
    );

endmodule
`default_nettype wire

>>> sim/scan_polar_to_cartesian_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_core_tb: self-checking bench for the lidar core
// Feeds range samples through the sample channel and checks every x/y point
// against an in-bench CORDIC predictor. Register settings change between
// phases. Both channels idle at random, and one phase fills the core.
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian_core_tb;

    localparam int MAX_BEAMS      = 4096;
    localparam int CORDIC_STAGES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 100;
    localparam logic [sp2c_pkg::CFG_INDEX_W-1:0] CFG_SPARE_IDX = 4'd9;

    typedef struct {
        logic signed [sp2c_pkg::COORD_W-1:0] x_mm;
        logic signed [sp2c_pkg::COORD_W-1:0] y_mm;
        logic [sp2c_pkg::INDEX_W-1:0]        beam_index;
    } point_t;

    class point_tracker;
        logic [sp2c_pkg::RANGE_W-1:0] keep_lo;
        logic [sp2c_pkg::RANGE_W-1:0] keep_hi;
        logic [sp2c_pkg::ANGLE_W-1:0] start_angle;
        logic [sp2c_pkg::STEP_W-1:0]  angle_step;
        logic [sp2c_pkg::INDEX_W-1:0] beam_counter;
        point_t                       points_due[$];
        int                           errors;

        function new();
            keep_lo      = '0;
            keep_hi      = 16'hFFFF;
            start_angle  = '0;
            angle_step   = 12'd16;
            beam_counter = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [sp2c_pkg::CFG_INDEX_W-1:0] idx,
                                logic [sp2c_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                sp2c_pkg::CFG_RANGE_MIN:   keep_lo = d;
                sp2c_pkg::CFG_RANGE_MAX:   keep_hi = d;
                sp2c_pkg::CFG_START_ANGLE: start_angle = d;
                sp2c_pkg::CFG_ANGLE_STEP:  angle_step = d[sp2c_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return points_due.size();
        endfunction

        function void note_sample(logic [sp2c_pkg::RANGE_W-1:0] r, logic s);
            logic [sp2c_pkg::INDEX_W-1:0] idx;
            logic [sp2c_pkg::INDEX_W:0]   nxt;
            logic [sp2c_pkg::ANGLE_W-1:0] ang;
            logic [sp2c_pkg::ANGLE_W-1:0] res;
            bit                           flip;
            longint                       x;
            longint                       y;
            longint                       z;
            longint                       dx;
            longint                       dy;
            int                           i;
            point_t                       p;
            idx = s ? '0 : beam_counter;
            nxt = idx + 1'b1;
            beam_counter = (nxt >= MAX_BEAMS) ? '0 : nxt[sp2c_pkg::INDEX_W-1:0];
            if (!(r > keep_lo && r < keep_hi))
                return;
            ang  = start_angle + idx * angle_step;
            flip = ang >= 16'd16384 && ang < 16'd49152;
            res  = flip ? (ang ^ 16'h8000) : ang;
            z    = longint'($signed(res)) * 65536;
            x    = longint'((64'(r) * 64'(sp2c_pkg::GAIN_Q32)) >> 16);
            y    = 0;
            for (i = 0; i < CORDIC_STAGES && i < sp2c_pkg::ATAN_ENTRIES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= longint'(sp2c_pkg::ATAN_Q32[i]);
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += longint'(sp2c_pkg::ATAN_Q32[i]);
                end
            end
            x = (x + 32768) >>> 16;
            y = (y + 32768) >>> 16;
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            if (x > 65535) x = 65535;
            else if (x < -65535) x = -65535;
            if (y > 65535) y = 65535;
            else if (y < -65535) y = -65535;
            p.x_mm       = x[sp2c_pkg::COORD_W-1:0];
            p.y_mm       = y[sp2c_pkg::COORD_W-1:0];
            p.beam_index = idx;
            points_due.push_back(p);
        endfunction

        function void compare_field(string field, logic [sp2c_pkg::INDEX_W-1:0] beam,
                                    logic signed [sp2c_pkg::COORD_W-1:0] want,
                                    logic signed [sp2c_pkg::COORD_W-1:0] got);
            if (got !== want)
            begin
                if (errors < REPORT_CAP)
                    $display("%0t: %s mismatch at beam %0d: expected %0d, actual %0d",
                             $time, field, beam, want, got);
                errors++;
            end
        endfunction

        function void check_point(logic signed [sp2c_pkg::COORD_W-1:0] x,
                                  logic signed [sp2c_pkg::COORD_W-1:0] y,
                                  logic [sp2c_pkg::INDEX_W-1:0] b);
            point_t e;
            if (points_due.size() == 0)
            begin
                if (errors < REPORT_CAP)
                    $display("%0t: extra point: expected none, actual x=%0d y=%0d beam=%0d",
                             $time, x, y, b);
                errors++;
                return;
            end
            e = points_due.pop_front();
            compare_field("x_mm", e.beam_index, e.x_mm, x);
            compare_field("y_mm", e.beam_index, e.y_mm, y);
            compare_field("beam_index", e.beam_index, e.beam_index, b);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    bit   hold_req;
    int   quiet_cycles;

    sp2c_sample_if smp();
    sp2c_cfg_if    cfg_ch();
    sp2c_point_if  pnt();

    point_tracker sb = new();

    scan_polar_to_cartesian_core #(
        .MAX_BEAMS     (MAX_BEAMS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .cfg    (cfg_ch),
        .point  (pnt)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pnt.valid && pnt.ready)
            sb.check_point(pnt.x_mm, pnt.y_mm, pnt.beam_index);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (smp.valid && smp.ready) || (pnt.valid && pnt.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // point receiver: random stalls, or one long hold on request
    initial
    begin
        pnt.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                pnt.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                pnt.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                pnt.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    task automatic send_sample(input logic [sp2c_pkg::RANGE_W-1:0] r, input logic s);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        smp.valid      <= 1'b1;
        smp.range_mm   <= r;
        smp.scan_start <= s;
        do @(posedge clk); while (!smp.ready);
        sb.note_sample(r, s);
    endtask

    task automatic write_reg(input logic [sp2c_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sp2c_pkg::CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // hold the sample channel until every point is out
    task automatic drain_points();
        @(negedge clk);
        smp.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_window(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [15:0] ang0, input logic [15:0] step);
        drain_points();
        write_reg(sp2c_pkg::CFG_RANGE_MIN, lo);
        write_reg(sp2c_pkg::CFG_RANGE_MAX, hi);
        write_reg(sp2c_pkg::CFG_START_ANGLE, ang0);
        write_reg(sp2c_pkg::CFG_ANGLE_STEP, step);
    endtask

    function automatic logic [sp2c_pkg::RANGE_W-1:0] pick_range();
        int lo;
        int hi;
        int k;
        lo = sb.keep_lo;
        hi = sb.keep_hi;
        k  = $urandom_range(0, 9);
        if (k == 0 || hi - lo < 2)
            return 16'($urandom);
        if (k == 1)
            return 16'(($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 2)) - 1);
        return 16'($urandom_range(lo + 1, hi - 1));
    endfunction

    task automatic run_scans(input int count, input int start_odds);
        int i;
        for (i = 0; i < count; i++)
            send_sample(pick_range(), $urandom_range(0, start_odds) == 0);
    endtask

    initial
    begin
        int       i;
        int       lo;
        int       hi;
        smp.valid      = 1'b0;
        smp.range_mm   = '0;
        smp.scan_start = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        rst_n          = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_sample(16'd65534, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd32768, 1'b0);
        send_sample(16'd12345, 1'b0);

        // narrow window, quadrant edge, step word wider than the register
        load_window(16'd100, 16'd200, 16'd16383, 16'hF001);
        write_reg(CFG_SPARE_IDX, 16'h1234);
        send_sample(16'd100, 1'b1);
        send_sample(16'd101, 1'b0);
        send_sample(16'd199, 1'b0);
        send_sample(16'd200, 1'b0);
        send_sample(16'd150, 1'b0);

        load_window(16'd0, 16'hFFFF, 16'd49150, 16'd1);
        for (i = 0; i < 4; i++)
            send_sample(16'd65534, i == 0);

        load_window(16'd65533, 16'hFFFF, 16'hFFFF, 16'd4095);
        send_sample(16'd65534, 1'b1);
        send_sample(16'd65534, 1'b0);
        send_sample(16'd65533, 1'b0);

        load_window(16'd0, 16'hFFFF, 16'd32767, 16'd1);
        send_sample(16'd65534, 1'b1);
        send_sample(16'd65534, 1'b0);

        load_window(16'd0, 16'hFFFF, 16'($urandom), 16'($urandom));
        run_scans(300, 40);

        // fill the core against a stalled receiver
        drain_points();
        hold_req = 1'b1;
        calm     = 1'b1;
        run_scans(40, 1000);
        calm     = 1'b0;

        lo = $urandom_range(0, 60000);
        load_window(16'(lo), 16'(lo + $urandom_range(2, 3000)), 16'd0, 16'd0);
        run_scans(250, 40);

        load_window(16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom));
        run_scans(30, 10);
        load_window(16'd0, 16'd0, 16'($urandom), 16'($urandom));
        run_scans(30, 10);

        // long scan, few points kept
        load_window(16'd64000, 16'hFFFF, 16'($urandom), 16'($urandom));
        send_sample(16'($urandom), 1'b1);
        for (i = 0; i < 399; i++)
        begin
            if ($urandom_range(0, 31) == 0)
                send_sample(16'($urandom_range(64001, 65534)), 1'b0);
            else
                send_sample(16'($urandom_range(0, 63999)), 1'b0);
        end

        repeat (3)
        begin
            lo = $urandom_range(0, 40000);
            hi = $urandom_range(lo, 65535);
            load_window(16'(lo), 16'(hi), 16'($urandom), 16'($urandom));
            run_scans(200, 50);
        end

        load_window(16'd0, 16'hFFFF, 16'hFFFF, 16'd4095);
        calm = 1'b1;
        run_scans(280, 60);

        drain_points();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/sp2c_pkg.sv
src/sp2c_if.sv
src/sp2c_front.sv
src/sp2c_queue.sv
src/sp2c_cordic.sv
src/scan_polar_to_cartesian_core.sv
sim/scan_polar_to_cartesian_core_tb.sv
